### sv/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared constants and types of the strict local maximum marker.
// ----------------------------------------------------------------------------
package slm_pkg;

  // largest grid side and the line buffer address width that follows from it
  localparam int MAX_SIZE    = 64;
  localparam int LB_AW       = $clog2(MAX_SIZE);

  // field and counter widths
  localparam int SIZE_W      = 7;
  localparam int HEIGHT_W    = 4;
  localparam int CNT_W       = 13;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // grid size after reset
  localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(MAX_SIZE);

  // one classified item, handed from front to back
  typedef struct packed {
    logic [LB_AW-1:0]    col;
    logic [HEIGHT_W-1:0] pix;
    logic                emit;
    logic                interior;
    logic                row_end;
    logic                restart;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                cavity;
    logic                row_end;
  } res_t;

endpackage

### sv/slm_front.sv
// ----------------------------------------------------------------------------
// slm_front
// Tracks raster position and emitted count, classifies each accepted item
// and builds the command that the back end carries out.
// ----------------------------------------------------------------------------
module slm_front import slm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic                accept_i,
  input  logic [HEIGHT_W-1:0] height_value_i,
  input  logic                drain_i,
  output cmd_t                cmd_o
);

  logic [SIZE_W-1:0] grid_q, grid_d;
  logic [CNT_W-1:0]  nn_q, nn_d;
  logic [SIZE_W-1:0] row_q, row_d;
  logic [LB_AW-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  emitted_q, emitted_d;

  logic [SIZE_W-1:0] n, n_cfg, c, c_inc, orow, ocol;
  logic [CNT_W-1:0]  emitted_next;
  logic              emit, interior, restart;

  // clamp a raw grid size into the supported range
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SIZE)) begin
      res = SIZE_W'(MAX_SIZE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign n     = clamp_size(grid_q);
  assign n_cfg = clamp_size(cfg_data_i);

  // classification of the current item
  always_comb begin
    c = {1'b0, col_q};
    if (c >= n) begin
      c = '0;
    end
    emit = ((row_q >= SIZE_W'(2)) || (row_q == SIZE_W'(1) && c >= SIZE_W'(1)))
           && (emitted_q < nn_q);
    orow = (c == '0) ? row_q - SIZE_W'(2) : row_q - SIZE_W'(1);
    ocol = (c == '0) ? n - SIZE_W'(1) : c - SIZE_W'(1);
    interior = (n >= SIZE_W'(3)) && (orow >= SIZE_W'(1)) && (orow <= n - SIZE_W'(2))
               && (ocol >= SIZE_W'(1)) && (ocol <= n - SIZE_W'(2));
    emitted_next = emitted_q + CNT_W'(emit);
    restart = (emitted_next >= nn_q);
    c_inc = c + SIZE_W'(1);
  end

  // command for the back end
  always_comb begin
    cmd_o.col      = c[LB_AW-1:0];
    cmd_o.pix      = drain_i ? '0 : height_value_i;
    cmd_o.emit     = emit;
    cmd_o.interior = interior;
    cmd_o.row_end  = (ocol == n - SIZE_W'(1));
    cmd_o.restart  = restart;
  end

  // position and count update
  always_comb begin
    grid_d    = grid_q;
    nn_d      = nn_q;
    row_d     = row_q;
    col_d     = col_q;
    emitted_d = emitted_q;
    if (cfg_we_i) begin
      grid_d    = cfg_data_i;
      nn_d      = CNT_W'(n_cfg) * CNT_W'(n_cfg);
      row_d     = '0;
      col_d     = '0;
      emitted_d = '0;
    end else if (accept_i) begin
      if (restart) begin
        row_d     = '0;
        col_d     = '0;
        emitted_d = '0;
      end else begin
        emitted_d = emitted_next;
        if (c_inc >= n) begin
          col_d = '0;
          row_d = (row_q + SIZE_W'(1) > n + SIZE_W'(1)) ? n + SIZE_W'(1)
                                                        : row_q + SIZE_W'(1);
        end else begin
          col_d = c_inc[LB_AW-1:0];
          row_d = row_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q    <= GRID_RESET;
      nn_q      <= CNT_W'(MAX_SIZE * MAX_SIZE);
      row_q     <= '0;
      col_q     <= '0;
      emitted_q <= '0;
    end else begin
      grid_q    <= grid_d;
      nn_q      <= nn_d;
      row_q     <= row_d;
      col_q     <= col_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

### sv/slm_cmd_queue.sv
// ----------------------------------------------------------------------------
// slm_cmd_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module slm_cmd_queue import slm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

### sv/slm_back.sv
// ----------------------------------------------------------------------------
// slm_back
// Line buffer memory, 3x2 stencil window and result buffer. Stage A reads
// the line buffers, stage B shifts the window, writes back and compares.
// ----------------------------------------------------------------------------
module slm_back import slm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic q_empty_i,
  input  cmd_t q_data_i,
  output logic q_pop_o,
  input  logic res_pop_i,
  output logic res_empty_o,
  output res_t res_o
);

  // line buffer entry: upper line in the high nibble, middle line below
  logic [2*HEIGHT_W-1:0] lb_mem_q [MAX_SIZE];
  logic [2*HEIGHT_W-1:0] rd_q, fwd_data_q;
  logic                  fwd_q;

  cmd_t                  b_cmd_q;
  logic                  b_valid_q;
  logic [HEIGHT_W-1:0]   win_q [6];

  res_t                  of_mem_q [2];
  logic                  of_wr_q, of_rd_q;
  logic [1:0]            of_count_q;
  logic                  of_full, of_push, of_pop;

  logic                  b_adv, a_load;
  logic [HEIGHT_W-1:0]   top, mid;
  res_t                  res_new;

  // pipeline advance
  assign of_full = (of_count_q == 2'd2);
  assign b_adv   = b_valid_q && (!b_cmd_q.emit || !of_full);
  assign a_load  = !q_empty_i && (!b_valid_q || b_adv);
  assign q_pop_o = a_load;

  // line buffer data with bypass of the write made in the load cycle
  assign top = fwd_q ? fwd_data_q[2*HEIGHT_W-1:HEIGHT_W] : rd_q[2*HEIGHT_W-1:HEIGHT_W];
  assign mid = fwd_q ? fwd_data_q[HEIGHT_W-1:0] : rd_q[HEIGHT_W-1:0];

  // line buffer memory: write back in stage B, registered read in stage A
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      lb_mem_q[b_cmd_q.col] <= {mid, b_cmd_q.pix};
    end
    if (a_load) begin
      rd_q       <= lb_mem_q[q_data_i.col];
      fwd_data_q <= {mid, b_cmd_q.pix};
    end
  end

  // stage B command and bypass flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (a_load) begin
        b_valid_q <= 1'b1;
        fwd_q     <= b_adv && (q_data_i.col == b_cmd_q.col);
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      b_cmd_q <= q_data_i;
    end
  end

  // stencil window: [0..2] column c-1 (up, centre, down), [3..5] column c-2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg_we_i || (b_adv && b_cmd_q.restart)) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (b_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= b_cmd_q.pix;
    end
  end

  // four neighbour compare
  always_comb begin
    res_new.height  = win_q[1];
    res_new.cavity  = b_cmd_q.interior && (win_q[1] > win_q[0]) && (win_q[1] > win_q[2])
                      && (win_q[1] > win_q[4]) && (win_q[1] > mid);
    res_new.row_end = b_cmd_q.row_end;
  end

  // result buffer
  assign of_push     = b_adv && b_cmd_q.emit;
  assign of_pop      = res_pop_i && (of_count_q != 2'd0);
  assign res_empty_o = (of_count_q == 2'd0);
  assign res_o       = of_mem_q[of_rd_q];

  always_ff @(posedge clk_i) begin
    if (of_push) begin
      of_mem_q[of_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q    <= 1'b0;
      of_rd_q    <= 1'b0;
      of_count_q <= 2'd0;
    end else begin
      if (of_push) begin
        of_wr_q <= !of_wr_q;
      end
      if (of_pop) begin
        of_rd_q <= !of_rd_q;
      end
      if (of_push && !of_pop) begin
        of_count_q <= of_count_q + 2'd1;
      end else if (of_pop && !of_push) begin
        of_count_q <= of_count_q - 2'd1;
      end
    end
  end

endmodule

### sv/strict_local_maximum_marker.sv
// ----------------------------------------------------------------------------
// strict_local_maximum_marker
// Marks interior grid cells that are strictly higher than their four
// direct neighbours, from a raster stream of height digits.
// ----------------------------------------------------------------------------
// Input side is a queue: a cell transfers when push is high and full is low.
// drain_i flushes one pending result; after the last cell of a grid send
// grid_size + 1 drain items. Results are a queue too: while empty is low the
// oldest result is on the result ports and it transfers when pop is high.
// The result of item p belongs to cell p - (grid_size + 1); the first
// grid_size + 1 items of a grid give none.
// One item per cycle is sustained while results are popped; the line buffer
// memory is read in stage A ahead of its write back in stage B, and a result
// passes the command queue, stage B and the result buffer on its way to the
// result ports. When pop stays low the two-entry result buffer fills, then
// stage B and the four-entry command queue, and full rises.
// Reset sets grid_size to 64 and restarts the stream; line buffer contents are
// not cleared. A configuration write (always ready) takes effect at once and
// restarts the stream; the user makes it only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module strict_local_maximum_marker import slm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [HEIGHT_W-1:0] height_value_i,
  input  logic                drain_i,
  output logic                empty,
  input  logic                pop,
  output logic [HEIGHT_W-1:0] cell_value_o,
  output logic                is_cavity_o,
  output logic                row_end_o
);

  logic cfg_we, accept, q_empty, q_pop;
  cmd_t front_cmd, q_head;
  res_t res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign accept      = push && !full;

  // front end: position tracking and classification
  slm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .height_value_i (height_value_i),
    .drain_i        (drain_i),
    .cmd_o          (front_cmd)
  );

  // command queue between front and back
  slm_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  // back end: line buffers, window and result buffer
  slm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .q_empty_i   (q_empty),
    .q_data_i    (q_head),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign cell_value_o = res.height;
  assign is_cavity_o  = res.cavity;
  assign row_end_o    = res.row_end;

endmodule
